FILE: rtl/tprs_pkg.sv
package tprs_pkg;

    // frame layout
    localparam logic [16:0] HDR_OFF_V4   = 17'd42;
    localparam logic [16:0] HDR_OFF_V6   = 17'd62;
    localparam logic [16:0] TEST_HDR_LEN = 17'd32;
    localparam logic [15:0] TEST_MARKER  = 16'hBEEF;
    localparam logic [15:0] TEST_FLAGS   = 16'h0000;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_MARKER = 2'd2;

    // time conversion
    localparam logic [31:0] NS_ROUND    = 32'd500000;
    localparam logic [31:0] MS_PER_SEC  = 32'd1000;
    // ceil(2^51 / 1e6): exact floor division for any 31-bit magnitude
    localparam logic [31:0] RECIP_MS    = 32'd2251799814;
    localparam int          RECIP_SHIFT = 51;
    localparam int          QUO_W       = 12;

    // per-packet fields carried down the pipeline
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] payload_length;
        logic [31:0] sequence_number;
        logic [31:0] configured_sec;
        logic [29:0] configured_nsec;
        logic        clear_counters;
    } t_item;

endpackage

FILE: rtl/test_packet_receive_statistics.sv
// Receive statistics for a UDP speed-test flow. Each input word carries the
// test-header fields of one received frame, its length, the local clock and a
// clear request; each one yields exactly one result word, in order, holding a
// status code and the counters as they stand after that frame. One word is
// accepted per clock cycle when the output side keeps up. Behind the input
// register come three stages of the millisecond conversion (difference,
// reciprocal multiply, sum and clamp) and then the statistics update that
// loads the result. The counters shown on the output ports are the live
// statistics registers and hold while a result waits. Rejected frames change
// nothing. Write ip_version only while idle.
module test_packet_receive_statistics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_ip_version,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_packet_length,
    input  logic [15:0] i_marker,
    input  logic [15:0] i_flag_word,
    input  logic [31:0] i_sequence_number,
    input  logic [15:0] i_payload_length,
    input  logic [31:0] i_configured_sec,
    input  logic [29:0] i_configured_nsec,
    input  logic [31:0] i_sent_sec,
    input  logic [29:0] i_sent_nsec,
    input  logic [31:0] i_now_sec,
    input  logic [29:0] i_now_nsec,
    input  logic        i_clear_counters,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_rx_packets,
    output logic [31:0] o_rx_bytes,
    output logic [31:0] o_out_of_order_packets,
    output logic [31:0] o_missing_packets,
    output logic [31:0] o_min_start_delay_ms,
    output logic [31:0] o_delay_var_ms,
    output logic [30:0] o_recent_lat_ms,
    output logic        o_lat_known,
    output logic        o_result_valid
);

    logic r_ip_version;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic rdy2, rdy3, rdy4, rdy_out;
    logic ld1, ld2, ld3, ld4, ld_out;

    // input register
    logic [15:0] r_packet_length;
    logic [15:0] r_marker;
    logic [15:0] r_flag_word;
    logic [31:0] r_sequence_number;
    logic [15:0] r_payload_length;
    logic [31:0] r_configured_sec;
    logic [29:0] r_configured_nsec;
    logic [31:0] r_sent_sec;
    logic [29:0] r_sent_nsec;
    logic [31:0] r_now_sec;
    logic [29:0] r_now_nsec;
    logic        r_clear_counters;

    tprs_pkg::t_item n_s2;
    tprs_pkg::t_item r_s2, r_s3, r_s4;

    logic [16:0] hdr_off;
    logic [16:0] frame_len;
    logic [16:0] pay_len;
    logic [16:0] room;
    logic        len_bad, marker_bad, pay_bad;

    logic [31:0] base_ms;
    logic [31:0] lat_ms;

    // statistics
    logic [31:0] r_last_seq, n_last_seq;
    logic [31:0] r_ref_sec, n_ref_sec;
    logic [29:0] r_ref_nsec, n_ref_nsec;
    logic [31:0] r_pkt, n_pkt;
    logic [31:0] r_bytes, n_bytes;
    logic [31:0] r_reorder, n_reorder;
    logic [31:0] r_loss, n_loss;
    logic [31:0] r_min, n_min;
    logic [31:0] r_var, n_var;
    logic [30:0] r_lat, n_lat;
    logic        r_seen, n_seen;
    logic        r_any, n_any;
    logic [1:0]  r_out_status;

    logic [31:0] e_pkt, e_bytes, e_reorder, e_loss, e_min, e_var;
    logic [30:0] e_lat;
    logic        e_seen;
    logic [31:0] expected;
    logic        ref_change;
    logic        below_min;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_version <= 1'b0;
        end else if (i_cfg_valid) begin
            r_ip_version <= i_cfg_ip_version;
        end
    end

    // handshake chain, each stage moves when the one after it has room
    assign rdy_out    = !r_out_valid || i_out_ready;
    assign rdy4       = !r_v4 || rdy_out;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign o_in_ready = !r_v1 || rdy2;

    assign ld1    = i_in_valid && o_in_ready;
    assign ld2    = r_v1 && rdy2;
    assign ld3    = r_v2 && rdy3;
    assign ld4    = r_v3 && rdy4;
    assign ld_out = r_v4 && rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy_out) begin
                r_out_valid <= r_v4;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_packet_length   <= i_packet_length;
            r_marker          <= i_marker;
            r_flag_word       <= i_flag_word;
            r_sequence_number <= i_sequence_number;
            r_payload_length  <= i_payload_length;
            r_configured_sec  <= i_configured_sec;
            r_configured_nsec <= i_configured_nsec;
            r_sent_sec        <= i_sent_sec;
            r_sent_nsec       <= i_sent_nsec;
            r_now_sec         <= i_now_sec;
            r_now_nsec        <= i_now_nsec;
            r_clear_counters  <= i_clear_counters;
        end
    end

    // frame checks: length, marker and flags, payload size
    always_comb begin
        hdr_off    = r_ip_version ? tprs_pkg::HDR_OFF_V6 : tprs_pkg::HDR_OFF_V4;
        frame_len  = {1'b0, r_packet_length};
        pay_len    = {1'b0, r_payload_length};
        room       = frame_len - hdr_off;
        len_bad    = frame_len < (hdr_off + tprs_pkg::TEST_HDR_LEN);
        marker_bad = (r_marker != tprs_pkg::TEST_MARKER) ||
                     (r_flag_word != tprs_pkg::TEST_FLAGS);
        pay_bad    = (pay_len < tprs_pkg::TEST_HDR_LEN) || (pay_len > room);

        if (len_bad) begin
            n_s2.status = tprs_pkg::ST_RANGE;
        end else if (marker_bad) begin
            n_s2.status = tprs_pkg::ST_MARKER;
        end else if (pay_bad) begin
            n_s2.status = tprs_pkg::ST_RANGE;
        end else begin
            n_s2.status = tprs_pkg::ST_OK;
        end
        n_s2.payload_length  = r_payload_length;
        n_s2.sequence_number = r_sequence_number;
        n_s2.configured_sec  = r_configured_sec;
        n_s2.configured_nsec = r_configured_nsec;
        n_s2.clear_counters  = r_clear_counters;
    end

    // carry the packet fields alongside the ms conversion
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_s2 <= n_s2;
        end
        if (ld3) begin
            r_s3 <= r_s2;
        end
        if (ld4) begin
            r_s4 <= r_s3;
        end
    end

    // start delay from the configured timestamp
    tprs_elapsed u_base (
        .i_clk       (i_clk),
        .i_load      ({ld4, ld3, ld2}),
        .i_now_sec   (r_now_sec),
        .i_now_nsec  (r_now_nsec),
        .i_from_sec  (r_configured_sec),
        .i_from_nsec (r_configured_nsec),
        .o_ms        (base_ms)
    );

    // latency from the transmit timestamp
    tprs_elapsed u_latency (
        .i_clk       (i_clk),
        .i_load      ({ld4, ld3, ld2}),
        .i_now_sec   (r_now_sec),
        .i_now_nsec  (r_now_nsec),
        .i_from_sec  (r_sent_sec),
        .i_from_nsec (r_sent_nsec),
        .o_ms        (lat_ms)
    );

    // statistics update
    always_comb begin
        // values after an optional clear
        e_pkt     = r_s4.clear_counters ? 32'd0 : r_pkt;
        e_bytes   = r_s4.clear_counters ? 32'd0 : r_bytes;
        e_reorder = r_s4.clear_counters ? 32'd0 : r_reorder;
        e_loss    = r_s4.clear_counters ? 32'd0 : r_loss;
        e_min     = r_s4.clear_counters ? 32'hFFFF_FFFF : r_min;
        e_var     = r_s4.clear_counters ? 32'd0 : r_var;
        e_lat     = r_s4.clear_counters ? 31'd0 : r_lat;
        e_seen    = r_s4.clear_counters ? 1'b0 : r_seen;

        expected   = r_last_seq + 32'd1;
        ref_change = (r_s4.configured_sec != r_ref_sec) ||
                     (r_s4.configured_nsec != r_ref_nsec);
        below_min  = base_ms < e_min;

        n_last_seq = r_last_seq;
        n_ref_sec  = r_ref_sec;
        n_ref_nsec = r_ref_nsec;
        n_pkt      = r_pkt;
        n_bytes    = r_bytes;
        n_reorder  = r_reorder;
        n_loss     = r_loss;
        n_min      = r_min;
        n_var      = r_var;
        n_lat      = r_lat;
        n_seen     = r_seen;
        n_any      = r_any;

        if (r_s4.status == tprs_pkg::ST_OK) begin
            n_pkt   = e_pkt + 32'd1;
            n_bytes = e_bytes + {16'd0, r_s4.payload_length};
            n_any   = 1'b1;
            if (expected > r_s4.sequence_number) begin
                // out of order: besides the packet and byte counts only the reorder count moves
                n_reorder = e_reorder + 32'd1;
                n_loss    = e_loss;
                n_min     = e_min;
                n_var     = e_var;
                n_lat     = e_lat;
                n_seen    = e_seen;
            end else begin
                n_reorder  = e_reorder;
                n_loss     = e_loss + (r_s4.sequence_number - expected);
                n_last_seq = r_s4.sequence_number;
                n_min      = e_min;
                n_var      = e_var;
                if (ref_change) begin
                    n_min      = below_min ? base_ms : e_min;
                    n_var      = below_min ? 32'd0 : (base_ms - e_min);
                    n_ref_sec  = r_s4.configured_sec;
                    n_ref_nsec = r_s4.configured_nsec;
                end
                n_lat  = lat_ms[30:0];
                n_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq <= 32'd0;
            r_ref_sec  <= 32'd0;
            r_ref_nsec <= 30'd0;
            r_pkt      <= 32'd0;
            r_bytes    <= 32'd0;
            r_reorder  <= 32'd0;
            r_loss     <= 32'd0;
            r_min      <= 32'hFFFF_FFFF;
            r_var      <= 32'd0;
            r_lat      <= 31'd0;
            r_seen     <= 1'b0;
            r_any      <= 1'b0;
        end else if (ld_out) begin
            r_last_seq <= n_last_seq;
            r_ref_sec  <= n_ref_sec;
            r_ref_nsec <= n_ref_nsec;
            r_pkt      <= n_pkt;
            r_bytes    <= n_bytes;
            r_reorder  <= n_reorder;
            r_loss     <= n_loss;
            r_min      <= n_min;
            r_var      <= n_var;
            r_lat      <= n_lat;
            r_seen     <= n_seen;
            r_any      <= n_any;
        end
    end

    // result status
    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_status <= r_s4.status;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_status               = r_out_status;
    assign o_rx_packets           = r_pkt;
    assign o_rx_bytes             = r_bytes;
    assign o_out_of_order_packets = r_reorder;
    assign o_missing_packets      = r_loss;
    assign o_min_start_delay_ms   = r_min;
    assign o_delay_var_ms         = r_var;
    assign o_recent_lat_ms        = r_lat;
    assign o_lat_known            = r_seen;
    assign o_result_valid         = r_any;

endmodule

FILE: rtl/tprs_elapsed.sv
module tprs_elapsed (
    input  logic        i_clk,
    input  logic [2:0]  i_load,
    input  logic [31:0] i_now_sec,
    input  logic [29:0] i_now_nsec,
    input  logic [31:0] i_from_sec,
    input  logic [29:0] i_from_nsec,
    output logic [31:0] o_ms
);

    logic [31:0] n_secs;
    logic [31:0] n_nsd;
    logic [31:0] nsd_neg;
    logic [30:0] n_mag;
    logic [31:0] r_secs;
    logic        r_neg1;
    logic [30:0] r_mag;

    logic [62:0] prod;
    logic [tprs_pkg::QUO_W-1:0] n_quo;
    logic [31:0] n_sms;
    logic [tprs_pkg::QUO_W-1:0] r_quo;
    logic        r_neg2;
    logic [31:0] r_sms;

    logic [31:0] quo_ext;
    logic [31:0] quo_signed;
    logic [31:0] ms_sum;
    logic [31:0] n_ms;
    logic [31:0] r_ms;

    // stage 1: seconds difference and rounded nanosecond difference as sign and magnitude
    always_comb begin
        n_secs  = i_now_sec - i_from_sec;
        n_nsd   = {2'b00, i_now_nsec} + tprs_pkg::NS_ROUND - {2'b00, i_from_nsec};
        nsd_neg = 32'd0 - n_nsd;
        n_mag   = n_nsd[31] ? nsd_neg[30:0] : n_nsd[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_secs <= n_secs;
            r_neg1 <= n_nsd[31];
            r_mag  <= n_mag;
        end
    end

    // stage 2: divide by one million with a reciprocal, seconds to ms
    always_comb begin
        prod  = {32'd0, r_mag} * {31'd0, tprs_pkg::RECIP_MS};
        n_quo = prod[tprs_pkg::RECIP_SHIFT +: tprs_pkg::QUO_W];
        n_sms = r_secs * tprs_pkg::MS_PER_SEC;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_quo  <= n_quo;
            r_neg2 <= r_neg1;
            r_sms  <= n_sms;
        end
    end

    // stage 3: signed quotient, sum, clamp negative to zero
    always_comb begin
        quo_ext    = {{(32 - tprs_pkg::QUO_W){1'b0}}, r_quo};
        quo_signed = r_neg2 ? (32'd0 - quo_ext) : quo_ext;
        ms_sum     = r_sms + quo_signed;
        n_ms       = ms_sum[31] ? 32'd0 : ms_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_ms <= n_ms;
        end
    end

    assign o_ms = r_ms;

endmodule

FILE: test/test_packet_receive_statistics_tb.sv
`timescale 1ns / 1ps

module test_packet_receive_statistics_tb;

    // fields of one received test header
    typedef struct packed {
        logic [15:0] packet_length;
        logic [15:0] marker;
        logic [15:0] flag_word;
        logic [31:0] sequence_number;
        logic [15:0] payload_length;
        logic [31:0] configured_sec;
        logic [29:0] configured_nsec;
        logic [31:0] sent_sec;
        logic [29:0] sent_nsec;
        logic [31:0] now_sec;
        logic [29:0] now_nsec;
        logic        clear_counters;
    } t_rx_hdr;

    // statistics reported for one header
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rx_packets;
        logic [31:0] rx_bytes;
        logic [31:0] out_of_order_packets;
        logic [31:0] missing_packets;
        logic [31:0] min_start_delay_ms;
        logic [31:0] delay_var_ms;
        logic [30:0] recent_lat_ms;
        logic        lat_known;
        logic        result_valid;
    } t_rx_stats;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_ip_version = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_packet_length = '0;
    logic [15:0] i_marker = '0;
    logic [15:0] i_flag_word = '0;
    logic [31:0] i_sequence_number = '0;
    logic [15:0] i_payload_length = '0;
    logic [31:0] i_configured_sec = '0;
    logic [29:0] i_configured_nsec = '0;
    logic [31:0] i_sent_sec = '0;
    logic [29:0] i_sent_nsec = '0;
    logic [31:0] i_now_sec = '0;
    logic [29:0] i_now_nsec = '0;
    logic        i_clear_counters = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_rx_packets;
    logic [31:0] o_rx_bytes;
    logic [31:0] o_out_of_order_packets;
    logic [31:0] o_missing_packets;
    logic [31:0] o_min_start_delay_ms;
    logic [31:0] o_delay_var_ms;
    logic [30:0] o_recent_lat_ms;
    logic        o_lat_known;
    logic        o_result_valid;

    test_packet_receive_statistics uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_ip_version       (i_cfg_ip_version),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_packet_length        (i_packet_length),
        .i_marker               (i_marker),
        .i_flag_word            (i_flag_word),
        .i_sequence_number      (i_sequence_number),
        .i_payload_length       (i_payload_length),
        .i_configured_sec       (i_configured_sec),
        .i_configured_nsec      (i_configured_nsec),
        .i_sent_sec             (i_sent_sec),
        .i_sent_nsec            (i_sent_nsec),
        .i_now_sec              (i_now_sec),
        .i_now_nsec             (i_now_nsec),
        .i_clear_counters       (i_clear_counters),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_status               (o_status),
        .o_rx_packets           (o_rx_packets),
        .o_rx_bytes             (o_rx_bytes),
        .o_out_of_order_packets (o_out_of_order_packets),
        .o_missing_packets      (o_missing_packets),
        .o_min_start_delay_ms   (o_min_start_delay_ms),
        .o_delay_var_ms         (o_delay_var_ms),
        .o_recent_lat_ms        (o_recent_lat_ms),
        .o_lat_known            (o_lat_known),
        .o_result_valid         (o_result_valid)
    );

    // predicted flow state
    logic        ip_v6 = 1'b0;
    logic [31:0] prev_seq = '0;
    logic [31:0] base_sec = '0;
    logic [29:0] base_nsec = '0;
    logic [31:0] pkt_count = '0;
    logic [31:0] byte_count = '0;
    logic [31:0] late_count = '0;
    logic [31:0] gap_count = '0;
    logic [31:0] delay_floor = '1;
    logic [31:0] delay_spread = '0;
    logic [30:0] last_lat = '0;
    logic        lat_measured = 1'b0;
    logic        counted_any = 1'b0;

    t_rx_stats pending_stats[$];
    t_rx_stats oldest;
    int        mismatches = 0;
    int        send_gap_pct = 0;
    int        sink_stall_pct = 0;
    int        stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // rounded milliseconds between two timestamps, negative reads as zero
    function automatic logic [31:0] elapsed_ms(input logic [31:0] to_s, input logic [29:0] to_ns,
                                               input logic [31:0] from_s,
                                               input logic [29:0] from_ns);
        logic [31:0] secs;
        longint      ns_diff;
        longint      quo;
        logic [31:0] ms;
        secs    = to_s - from_s;
        ns_diff = longint'(to_ns) + 500000 - longint'(from_ns);
        quo     = ns_diff / 1000000;
        ms      = secs * 32'd1000 + quo[31:0];
        return ms[31] ? 32'd0 : ms;
    endfunction

    // header checks and statistics update for one word
    function automatic t_rx_stats count_packet(input t_rx_hdr h);
        t_rx_stats   s;
        logic [16:0] off;
        logic [31:0] next_seq;
        logic [31:0] delay;
        logic [31:0] lat;
        off = ip_v6 ? tprs_pkg::HDR_OFF_V6 : tprs_pkg::HDR_OFF_V4;
        if ({1'b0, h.packet_length} < off + tprs_pkg::TEST_HDR_LEN) begin
            s.status = tprs_pkg::ST_RANGE;
        end else if (h.marker != tprs_pkg::TEST_MARKER ||
                     h.flag_word != tprs_pkg::TEST_FLAGS) begin
            s.status = tprs_pkg::ST_MARKER;
        end else if ({1'b0, h.payload_length} < tprs_pkg::TEST_HDR_LEN ||
                     {1'b0, h.payload_length} > {1'b0, h.packet_length} - off) begin
            s.status = tprs_pkg::ST_RANGE;
        end else begin
            s.status = tprs_pkg::ST_OK;
        end

        if (s.status == tprs_pkg::ST_OK) begin
            if (h.clear_counters) begin
                pkt_count    = '0;
                byte_count   = '0;
                late_count   = '0;
                gap_count    = '0;
                delay_floor  = '1;
                delay_spread = '0;
                last_lat     = '0;
                lat_measured = 1'b0;
            end
            pkt_count  = pkt_count + 32'd1;
            byte_count = byte_count + {16'd0, h.payload_length};
            next_seq   = prev_seq + 32'd1;
            if (next_seq > h.sequence_number) begin
                late_count = late_count + 32'd1;
            end else begin
                gap_count = gap_count + (h.sequence_number - next_seq);
                prev_seq  = h.sequence_number;
                // start delay only moves when the configured time changes
                if (h.configured_sec != base_sec || h.configured_nsec != base_nsec) begin
                    delay = elapsed_ms(h.now_sec, h.now_nsec, h.configured_sec,
                                       h.configured_nsec);
                    if (delay < delay_floor) begin
                        delay_floor  = delay;
                        lat_measured = 1'b1;
                    end
                    delay_spread = delay - delay_floor;
                    base_sec     = h.configured_sec;
                    base_nsec    = h.configured_nsec;
                end
                lat          = elapsed_ms(h.now_sec, h.now_nsec, h.sent_sec, h.sent_nsec);
                last_lat     = lat[30:0];
                lat_measured = 1'b1;
            end
            counted_any = 1'b1;
        end

        s.rx_packets           = pkt_count;
        s.rx_bytes             = byte_count;
        s.out_of_order_packets = late_count;
        s.missing_packets      = gap_count;
        s.min_start_delay_ms   = delay_floor;
        s.delay_var_ms         = delay_spread;
        s.recent_lat_ms        = last_lat;
        s.lat_known            = lat_measured;
        s.result_valid         = counted_any;
        return s;
    endfunction

    // no gap, or with pct percent odds a gap: mostly short ones, a few long ones
    function automatic int pick_gap(input int pct);
        if (pct == 0 || $urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    // a well-formed header with fixed timestamps
    function automatic t_rx_hdr good_word(input logic [31:0] seq_num,
                                          input logic [15:0] plen, input logic [15:0] pay);
        t_rx_hdr h;
        h.packet_length   = plen;
        h.marker          = tprs_pkg::TEST_MARKER;
        h.flag_word       = tprs_pkg::TEST_FLAGS;
        h.sequence_number = seq_num;
        h.payload_length  = pay;
        h.configured_sec  = 32'd5000;
        h.configured_nsec = 30'd0;
        h.sent_sec        = 32'd4999;
        h.sent_nsec       = 30'd999000000;
        h.now_sec         = 32'd5000;
        h.now_nsec        = 30'd1300000;
        h.clear_counters  = 1'b0;
        return h;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // send one word, keeping valid high across back-to-back words
    task automatic send_word(input t_rx_hdr h);
        int gap;
        gap = pick_gap(send_gap_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pending_stats.push_back(count_packet(h));
        i_in_valid        <= 1'b1;
        i_packet_length   <= h.packet_length;
        i_marker          <= h.marker;
        i_flag_word       <= h.flag_word;
        i_sequence_number <= h.sequence_number;
        i_payload_length  <= h.payload_length;
        i_configured_sec  <= h.configured_sec;
        i_configured_nsec <= h.configured_nsec;
        i_sent_sec        <= h.sent_sec;
        i_sent_nsec       <= h.sent_nsec;
        i_now_sec         <= h.now_sec;
        i_now_nsec        <= h.now_nsec;
        i_clear_counters  <= h.clear_counters;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and let every predicted result come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_ip_version(input logic v6);
        i_cfg_valid      <= 1'b1;
        i_cfg_ip_version <= v6;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ip_v6 = v6;
        @(posedge i_clk);
    endtask

    // length, marker, flag and payload size checks on the ipv4 offset
    task automatic test_header_checks();
        t_rx_hdr h;
        send_word(good_word(32'd1, 16'd74, 16'd32));
        send_word(good_word(32'd2, 16'd73, 16'd32));
        h = '0;
        send_word(h);
        h = good_word(32'd2, 16'd200, 16'd100);
        h.marker = 16'hBEEE;
        send_word(h);
        h = good_word(32'd2, 16'd200, 16'd100);
        h.flag_word = 16'h8000;
        send_word(h);
        send_word(good_word(32'd2, 16'd200, 16'd31));
        send_word(good_word(32'd2, 16'd200, 16'd159));
        send_word(good_word(32'd2, 16'hFFFF, 16'd65493));
        // clear on a rejected frame does nothing
        h = good_word(32'd3, 16'd200, 16'd100);
        h.marker         = 16'h0000;
        h.clear_counters = 1'b1;
        send_word(h);
    endtask

    // gaps, duplicates, late packets, clear and sequence wrap
    task automatic test_sequence_tracking();
        t_rx_hdr h;
        send_word(good_word(32'd10, 16'd300, 16'd200));
        send_word(good_word(32'd10, 16'd300, 16'd200));
        send_word(good_word(32'd5, 16'd300, 16'd64));
        h = good_word(32'd11, 16'd300, 16'd100);
        h.clear_counters = 1'b1;
        send_word(h);
        send_word(good_word(32'hFFFFFFFF, 16'd300, 16'd100));
        send_word(good_word(32'd0, 16'd300, 16'd100));
    endtask

    // start delay floor and spread, negative and overflowed latency, odd nsec
    task automatic test_start_delay_and_latency();
        t_rx_hdr h;
        h = good_word(32'd1, 16'd300, 16'd100);
        h.configured_sec = 32'd4999;
        send_word(h);
        h = good_word(32'd2, 16'd300, 16'd100);
        h.configured_sec = 32'd4997;
        h.sent_sec       = 32'd5001;
        send_word(h);
        h = good_word(32'd3, 16'd300, 16'd100);
        h.configured_sec = 32'd5001;
        send_word(h);
        h = good_word(32'd4, 16'd300, 16'd100);
        h.configured_sec  = 32'd4990;
        h.configured_nsec = 30'h3FFFFFFF;
        h.now_nsec        = 30'h3FFFFFFF;
        h.sent_sec        = h.now_sec - 32'd3000000;
        h.sent_nsec       = 30'd0;
        send_word(h);
    endtask

    // length limits move with the ipv6 offset
    task automatic test_ipv6_offsets();
        send_word(good_word(32'd5, 16'd93, 16'd32));
        send_word(good_word(32'd5, 16'd94, 16'd32));
        send_word(good_word(32'd6, 16'd94, 16'd33));
        send_word(good_word(32'd6, 16'hFFFF, 16'd65473));
    endtask

    // mostly well-formed flow traffic with some corrupted and noise words
    task automatic test_random_traffic(input int count);
        t_rx_hdr     h;
        int          kind;
        int          pick;
        int unsigned off;
        logic [31:0] now_s;
        logic [31:0] cfg_s;
        logic [29:0] cfg_ns;
        now_s  = $urandom;
        cfg_s  = now_s - $urandom_range(3);
        cfg_ns = 30'($urandom_range(999999999));
        for (int n = 0; n < count; n++) begin
            off = ip_v6 ? 62 : 42;
            if ($urandom_range(3) == 0) now_s = now_s + 32'd1;
            // a new test run now and then
            if ($urandom_range(19) == 0) begin
                cfg_s  = now_s - $urandom_range(3);
                cfg_ns = 30'($urandom_range(999999999));
            end
            h.now_sec         = now_s;
            h.now_nsec        = 30'($urandom_range(999999999));
            h.configured_sec  = cfg_s;
            h.configured_nsec = cfg_ns;
            h.sent_sec        = now_s - $urandom_range(1);
            h.sent_nsec       = 30'($urandom_range(999999999));
            if ($urandom_range(15) == 0) h.sent_sec = now_s + 32'd1;
            h.packet_length   = 16'($urandom_range(off + 32 + 1500, off + 32));
            h.payload_length  = 16'($urandom_range(h.packet_length - off, 32));
            h.marker          = tprs_pkg::TEST_MARKER;
            h.flag_word       = tprs_pkg::TEST_FLAGS;
            h.clear_counters  = ($urandom_range(39) == 0);

            // sequence relative to the last one counted
            pick = $urandom_range(99);
            if (pick < 78) h.sequence_number = prev_seq + 32'd1;
            else if (pick < 88) h.sequence_number = prev_seq + $urandom_range(20, 2);
            else if (pick < 96) h.sequence_number = prev_seq - $urandom_range(5);
            else h.sequence_number = $urandom;

            kind = $urandom_range(99);
            if (kind < 8) begin
                // line noise
                h.packet_length   = 16'($urandom);
                h.marker          = 16'($urandom);
                h.flag_word       = 16'($urandom);
                h.sequence_number = $urandom;
                h.payload_length  = 16'($urandom);
                h.configured_sec  = $urandom;
                h.configured_nsec = 30'($urandom);
                h.sent_sec        = $urandom;
                h.sent_nsec       = 30'($urandom);
                h.now_sec         = $urandom;
                h.now_nsec        = 30'($urandom);
                h.clear_counters  = 1'($urandom);
            end else if (kind < 11) begin
                h.packet_length = 16'($urandom_range(off + 31));
            end else if (kind < 14) begin
                if ($urandom_range(1)) h.payload_length = 16'($urandom_range(31));
                else h.payload_length = 16'(h.packet_length - off + $urandom_range(4, 1));
            end else if (kind < 16) begin
                if ($urandom_range(1)) h.marker = h.marker ^ (16'h1 << $urandom_range(15));
                else h.flag_word = 16'h1 << $urandom_range(15);
            end else if (kind < 19) begin
                h.packet_length  = 16'($urandom_range(65535, 1600));
                h.payload_length = 16'($urandom_range(h.packet_length - off, 32));
            end else if (kind < 22) begin
                // nanosecond fields past one second
                h.now_nsec        = 30'($urandom_range(30'h3FFFFFFF, 1000000000));
                h.sent_nsec       = 30'($urandom_range(30'h3FFFFFFF, 1000000000));
                h.configured_nsec = 30'($urandom_range(30'h3FFFFFFF, 1000000000));
            end
            send_word(h);
        end
    endtask

    // sender holds off until the pipeline is empty, then resumes
    task automatic test_drain_pause();
        test_random_traffic(100);
        wait_drained();
        test_random_traffic(100);
    endtask

    // result side backpressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            stall_left = pick_gap(sink_stall_pct);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_stats.size() == 0) begin
                $error("result word with no prediction waiting");
                mismatches++;
            end else begin
                oldest = pending_stats.pop_front();
                check_field("status", oldest.status, o_status);
                check_field("rx_packets", oldest.rx_packets, o_rx_packets);
                check_field("rx_bytes", oldest.rx_bytes, o_rx_bytes);
                check_field("out_of_order_packets", oldest.out_of_order_packets,
                            o_out_of_order_packets);
                check_field("missing_packets", oldest.missing_packets, o_missing_packets);
                check_field("min_start_delay_ms", oldest.min_start_delay_ms,
                            o_min_start_delay_ms);
                check_field("delay_var_ms", oldest.delay_var_ms, o_delay_var_ms);
                check_field("recent_lat_ms", oldest.recent_lat_ms, o_recent_lat_ms);
                check_field("lat_known", oldest.lat_known, o_lat_known);
                check_field("result_valid", oldest.result_valid, o_result_valid);
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct   = 30;
        sink_stall_pct = 30;
        write_ip_version(1'b0);
        test_header_checks();
        test_sequence_tracking();
        test_start_delay_and_latency();
        wait_drained();

        write_ip_version(1'b1);
        test_ipv6_offsets();
        test_random_traffic(400);
        test_drain_pause();
        wait_drained();

        // back to back with no idling
        write_ip_version(1'b0);
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        test_random_traffic(250);

        // heavy idling on both sides
        send_gap_pct   = 60;
        sink_stall_pct = 60;
        test_random_traffic(250);
        wait_drained();

        write_ip_version(1'b1);
        send_gap_pct   = 20;
        sink_stall_pct = 40;
        test_random_traffic(100);
        wait_drained();

        if (mismatches == 0) begin
            $display("test_packet_receive_statistics: match");
        end else begin
            $display("test_packet_receive_statistics: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("test_packet_receive_statistics: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tprs_pkg.sv
rtl/tprs_elapsed.sv
rtl/test_packet_receive_statistics.sv
test/test_packet_receive_statistics_tb.sv
